@@ hdl/elaps_pkg.sv @@
`default_nettype none
package elaps_pkg;

  localparam int unsigned AngleSteps = 3142;
  localparam logic [11:0] StepsLast = 12'(AngleSteps);
  localparam logic [23:0] DeltaQ22 = 24'd4194;
  localparam logic [23:0] PiQ22 = 24'd13176795;
  localparam logic [23:0] HalfPiQ22 = 24'd6588397;
  localparam logic [32:0] OneQ30 = 33'h0_4000_0000;
  localparam logic [23:0] AxisReset = 24'd65536;
  localparam logic [7:0] CountReset = 8'd30;

  localparam logic [3:0] IdxSinLast = 4'd4;
  localparam logic [3:0] IdxCosFirst = 4'd5;
  localparam logic [3:0] IdxCosLast = 4'd10;

  typedef enum logic [1:0] {
    REG_SEMI_A = 2'd0,
    REG_SEMI_B = 2'd1,
    REG_COUNT  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_STEP, ST_CMPA, ST_CMPB, ST_CMPC, ST_FOLD, ST_X2, ST_TP, ST_DQ, ST_DR,
    ST_SM, ST_CY, ST_CZ, ST_AS, ST_BC, ST_SQA, ST_SQB, ST_ROOT, ST_ACC, ST_DONE
  } state_e;

  typedef struct packed {
    logic              op;
    logic signed [23:0] height;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic               steps_remaining;
  } out_word_t;

  localparam logic [31:0] M110 = 32'((64'd1 << 32) / 110);
  localparam logic [31:0] M72  = 32'((64'd1 << 32) / 72);
  localparam logic [31:0] M42  = 32'((64'd1 << 32) / 42);
  localparam logic [31:0] M20  = 32'((64'd1 << 32) / 20);
  localparam logic [31:0] M6   = 32'((64'd1 << 32) / 6);
  localparam logic [31:0] M132 = 32'((64'd1 << 32) / 132);
  localparam logic [31:0] M90  = 32'((64'd1 << 32) / 90);
  localparam logic [31:0] M56  = 32'((64'd1 << 32) / 56);
  localparam logic [31:0] M30  = 32'((64'd1 << 32) / 30);
  localparam logic [31:0] M12  = 32'((64'd1 << 32) / 12);
  localparam logic [31:0] M2   = 32'((64'd1 << 32) / 2);

  function automatic logic [7:0] term_k(input logic [3:0] idx);
    case (idx)
      4'd0: term_k = 8'd110;
      4'd1: term_k = 8'd72;
      4'd2: term_k = 8'd42;
      4'd3: term_k = 8'd20;
      4'd4: term_k = 8'd6;
      4'd5: term_k = 8'd132;
      4'd6: term_k = 8'd90;
      4'd7: term_k = 8'd56;
      4'd8: term_k = 8'd30;
      4'd9: term_k = 8'd12;
      4'd10: term_k = 8'd2;
      default: term_k = 8'd1;
    endcase
  endfunction

  function automatic logic [31:0] term_m(input logic [3:0] idx);
    case (idx)
      4'd0: term_m = M110;
      4'd1: term_m = M72;
      4'd2: term_m = M42;
      4'd3: term_m = M20;
      4'd4: term_m = M6;
      4'd5: term_m = M132;
      4'd6: term_m = M90;
      4'd7: term_m = M56;
      4'd8: term_m = M30;
      4'd9: term_m = M12;
      4'd10: term_m = M2;
      default: term_m = 32'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/ellipse_arc_length_point_sampler_unit.sv @@
// a start word sweeps every arc element once, summing them into the perimeter
// a fetch word walks angle steps until a hit or the sweep ends, or goes straight to its result if swept out
// one angle step: 37 passes through the shared 32x32 multiplier for the arc element,
// then a bit-pair square root; one word in the unit at a time
// rst_ni asynchronous active low: registers to defaults, progress and perimeter zero
`default_nettype none
module ellipse_arc_length_point_sampler_unit import elaps_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_word_t   in_word_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_word_t       out_word_o,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  state_e state_q, state_d;
  logic phase_q, phase_d;
  logic [23:0] sa_q, sb_q;
  logic [7:0] pc_q;
  logic [23:0] angle_q, angle_d;
  logic [39:0] arc_q, arc_d, perim_q, perim_d;
  logic [7:0] ni_q, ni_d;
  logic [11:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  logic op_q, op_d, hit_q, hit_d;
  logic signed [23:0] height_q, height_d, cy_q, cy_d, cz_q, cz_d;
  logic [30:0] x_q, x_d, u_q, u_d, sm_q, sm_d, cm_q, cm_d;
  logic [31:0] x2_q, x2_d, p_q, p_d, qt_q, qt_d;
  logic sn_q, sn_d, cn_q, cn_d;
  logic [3:0] idx_q, idx_d;
  logic [24:0] as_q, as_d, bc_q, bc_d;
  logic [63:0] v_q, v_d, r_q, r_d, bit_q, bit_d;
  logic [47:0] cmpa_q, cmpa_d, cmpb_q, cmpb_d;
  logic [63:0] mul_q, mul_d;
  logic [31:0] mul_a, mul_b;
  logic [7:0] cmp_x;
  logic [39:0] cmp_y;
  logic [47:0] cmp_prod;

  logic [23:0] ft;
  logic fsn, fcn;
  logic [31:0] rem;
  logic [32:0] qf;
  logic [63:0] rb;
  logic [39:0] acc_sum;
  logic [11:0] step_inc;
  logic cfg_wr;

  function automatic logic signed [23:0] sat24(input logic [24:0] mag, input logic neg);
    logic [24:0] m;
    m = mag;
    if (neg) begin
      if (m > 25'd8388608) m = 25'd8388608;
      sat24 = 24'(25'h100_0000 - m);
    end else begin
      sat24 = (m > 25'd8388607) ? 24'sd8388607 : 24'(m);
    end
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o = out_q;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_SEMI_A: prdata = {8'd0, sa_q};
      REG_SEMI_B: prdata = {8'd0, sb_q};
      REG_COUNT:  prdata = {24'd0, pc_q};
      default:    prdata = 32'd0;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_q)
      ST_X2: begin mul_a = {1'b0, x_q}; mul_b = {1'b0, x_q}; end
      ST_TP: begin mul_a = x2_q; mul_b = {1'b0, u_q}; end
      ST_DQ: begin mul_a = p_q; mul_b = term_m(idx_q); end
      ST_DR: begin mul_a = qt_q; mul_b = {24'd0, term_k(idx_q)}; end
      ST_SM: begin mul_a = {1'b0, x_q}; mul_b = {1'b0, u_q}; end
      ST_AS: begin mul_a = {8'd0, sa_q}; mul_b = {1'b0, sm_q}; end
      ST_BC: begin mul_a = {8'd0, sb_q}; mul_b = {1'b0, cm_q}; end
      ST_SQA: begin mul_a = {7'd0, as_q}; mul_b = {7'd0, as_q}; end
      ST_SQB: begin mul_a = {7'd0, bc_q}; mul_b = {7'd0, bc_q}; end
      ST_CY: begin mul_a = {8'd0, sb_q}; mul_b = {1'b0, sm_q}; end
      ST_CZ: begin mul_a = {8'd0, sa_q}; mul_b = {1'b0, cm_q}; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
    mul_d = 64'(mul_a) * 64'(mul_b);
    cmp_x = (state_q == ST_CMPA) ? pc_q : ni_q;
    cmp_y = (state_q == ST_CMPA) ? arc_q : perim_q;
    cmp_prod = 48'(cmp_x) * 48'(cmp_y);
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    angle_d = angle_q;
    arc_d = arc_q;
    perim_d = perim_q;
    ni_d = ni_q;
    step_d = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    op_d = op_q;
    hit_d = hit_q;
    height_d = height_q;
    cy_d = cy_q;
    cz_d = cz_q;
    x_d = x_q;
    u_d = u_q;
    sm_d = sm_q;
    cm_d = cm_q;
    x2_d = x2_q;
    p_d = p_q;
    qt_d = qt_q;
    sn_d = sn_q;
    cn_d = cn_q;
    idx_d = idx_q;
    as_d = as_q;
    bc_d = bc_q;
    v_d = v_q;
    r_d = r_q;
    bit_d = bit_q;
    cmpa_d = cmpa_q;
    cmpb_d = cmpb_q;

    ft = angle_q;
    fsn = 1'b0;
    fcn = 1'b0;
    if (ft >= PiQ22) begin
      ft = ft - PiQ22;
      fsn = 1'b1;
      fcn = 1'b1;
    end
    if (ft > HalfPiQ22) begin
      ft = PiQ22 - ft;
      fcn = ~fcn;
    end
    rem = p_q - mul_q[31:0];
    qf = {1'b0, qt_q} + ((rem >= {24'd0, term_k(idx_q)}) ? 33'd1 : 33'd0);
    rb = r_q + bit_q;
    acc_sum = (op_q ? arc_q : perim_q) + r_q[39:0];
    step_inc = step_q + 12'd1;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d = in_word_i.op;
          height_d = in_word_i.height;
          hit_d = 1'b0;
          cy_d = 24'sd0;
          cz_d = 24'sd0;
          if (!in_word_i.op) begin
            angle_d = 24'd0;
            step_d = 12'd0;
            perim_d = 40'd0;
            state_d = ST_STEP;
          end else if (step_q >= StepsLast) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        angle_d = angle_q + DeltaQ22;
        state_d = op_q ? ST_CMPA : ST_FOLD;
      end
      ST_CMPA: begin
        cmpa_d = cmp_prod;
        state_d = ST_CMPB;
      end
      ST_CMPB: begin
        cmpb_d = cmp_prod;
        state_d = ST_CMPC;
      end
      ST_CMPC: begin
        if (perim_q != 40'd0 && cmpa_q >= cmpb_q) begin
          hit_d = 1'b1;
          if (ni_q != 8'd255) ni_d = ni_q + 8'd1;
        end
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        x_d = {ft[22:0], 8'd0};
        sn_d = fsn;
        cn_d = fcn;
        state_d = ST_X2;
      end
      ST_X2: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          x2_d = mul_q[61:30];
          p_d = mul_q[61:30];
          idx_d = 4'd0;
          state_d = ST_DQ;
        end
      end
      ST_TP: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          p_d = mul_q[61:30];
          state_d = ST_DQ;
        end
      end
      ST_DQ: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          qt_d = mul_q[63:32];
          state_d = ST_DR;
        end
      end
      ST_DR: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          u_d = (qf >= OneQ30) ? 31'd0 : 31'(OneQ30 - qf);
          idx_d = idx_q + 4'd1;
          if (idx_q == IdxSinLast) begin
            state_d = ST_SM;
          end else if (idx_q == IdxCosLast) begin
            cm_d = (qf >= OneQ30) ? 31'd0 : 31'(OneQ30 - qf);
            state_d = (op_q && hit_q) ? ST_CY : ST_AS;
          end else begin
            state_d = ST_TP;
          end
        end
      end
      ST_SM: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          sm_d = mul_q[60:30];
          p_d = x2_q;
          idx_d = IdxCosFirst;
          state_d = ST_DQ;
        end
      end
      ST_CY: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          cy_d = sat24(mul_q[54:30], sn_q);
          state_d = ST_CZ;
        end
      end
      ST_CZ: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          cz_d = sat24(mul_q[54:30], cn_q);
          state_d = ST_AS;
        end
      end
      ST_AS: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          as_d = mul_q[54:30];
          state_d = ST_BC;
        end
      end
      ST_BC: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          bc_d = mul_q[54:30];
          state_d = ST_SQA;
        end
      end
      ST_SQA: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          v_d = mul_q;
          state_d = ST_SQB;
        end
      end
      ST_SQB: begin
        phase_d = ~phase_q;
        if (phase_q) begin
          v_d = v_q + mul_q;
          r_d = 64'd0;
          bit_d = 64'd1 << 62;
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (bit_q == 64'd0) begin
          state_d = ST_ACC;
        end else begin
          if (v_q >= rb) begin
            v_d = v_q - rb;
            r_d = (r_q >> 1) + bit_q;
          end else begin
            r_d = r_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      end
      ST_ACC: begin
        step_d = step_inc;
        if (!op_q) begin
          perim_d = acc_sum;
          if (step_inc == StepsLast) begin
            angle_d = 24'd0;
            arc_d = 40'd0;
            ni_d = 8'd0;
            step_d = 12'd0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_STEP;
          end
        end else begin
          arc_d = acc_sum;
          state_d = (hit_q || step_inc == StepsLast) ? ST_DONE : ST_STEP;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.found = op_q && hit_q;
          out_d.coord_x = (op_q && hit_q) ? height_q : 24'sd0;
          out_d.coord_y = cy_q;
          out_d.coord_z = cz_q;
          out_d.steps_remaining = (step_q < StepsLast);
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
      sa_q <= AxisReset;
      sb_q <= AxisReset;
      pc_q <= CountReset;
      angle_q <= 24'd0;
      arc_q <= 40'd0;
      perim_q <= 40'd0;
      ni_q <= 8'd0;
      step_q <= 12'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      angle_q <= angle_d;
      arc_q <= arc_d;
      perim_q <= perim_d;
      ni_q <= ni_d;
      step_q <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_SEMI_A: sa_q <= pwdata[23:0];
          REG_SEMI_B: sb_q <= pwdata[23:0];
          REG_COUNT:  pc_q <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    op_q <= op_d;
    hit_q <= hit_d;
    height_q <= height_d;
    cy_q <= cy_d;
    cz_q <= cz_d;
    x_q <= x_d;
    u_q <= u_d;
    sm_q <= sm_d;
    cm_q <= cm_d;
    x2_q <= x2_d;
    p_q <= p_d;
    qt_q <= qt_d;
    sn_q <= sn_d;
    cn_q <= cn_d;
    idx_q <= idx_d;
    as_q <= as_d;
    bc_q <= bc_d;
    v_q <= v_d;
    r_q <= r_d;
    bit_q <= bit_d;
    cmpa_q <= cmpa_d;
    cmpb_q <= cmpb_d;
    mul_q <= mul_d;
  end

endmodule
`default_nettype wire

@@ hdl/elaps_checker.sv @@
`default_nettype none
module elaps_checker import elaps_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_word_t  in_word_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_word_t out_word_o
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // one word at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.found |-> out_word_o.coord_x == 24'sd0 &&
      out_word_o.coord_y == 24'sd0 && out_word_o.coord_z == 24'sd0)
    else $error("coordinates set without a point");

endmodule

bind ellipse_arc_length_point_sampler_unit elaps_checker u_elaps_checker (.*);
`default_nettype wire
